// ----- rtl/vrfp_pkg.sv -----
package vrfp_pkg;

  // Header layout
  localparam int unsigned HdrLen  = 10;
  localparam int unsigned CmdHiAt = 4;
  localparam int unsigned FlgHiAt = 6;

  localparam logic [15:0] RespCmd = 16'h021d;

  // Flag bits selecting the body fields
  localparam int unsigned FlagSubdev = 0;
  localparam int unsigned FlagModule = 1;
  localparam int unsigned FlagMcu    = 2;
  localparam int unsigned FlagMd5    = 8;
  localparam int unsigned FlagHttp   = 9;
  localparam int unsigned FlagHttps  = 10;

  localparam logic [7:0] CommaChar = 8'h2c;

  // Body field slots, in walk order
  localparam logic [2:0] SlotSubdev = 3'd0;
  localparam logic [2:0] SlotModule = 3'd1;
  localparam logic [2:0] SlotMcu    = 3'd2;
  localparam logic [2:0] SlotMd5    = 3'd3;
  localparam logic [2:0] SlotUrl    = 3'd4;
  localparam int unsigned NumSlots  = 5;

  // Result kinds
  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  // Field ids carried on data results
  localparam logic [2:0] FidSubdev   = 3'd0;
  localparam logic [2:0] FidModuleHw = 3'd1;
  localparam logic [2:0] FidModuleSw = 3'd2;
  localparam logic [2:0] FidMcuHw    = 3'd3;
  localparam logic [2:0] FidMcuSw    = 3'd4;
  localparam logic [2:0] FidMd5      = 3'd5;
  localparam logic [2:0] FidUrl      = 3'd6;

  // Status codes
  localparam logic [3:0] StOk       = 4'd0;
  localparam logic [3:0] StShort    = 4'd1;
  localparam logic [3:0] StUnknown  = 4'd2;
  localparam logic [3:0] StSubdev   = 4'd3;
  localparam logic [3:0] StModule   = 4'd4;
  localparam logic [3:0] StMcu      = 4'd5;
  localparam logic [3:0] StMd5      = 4'd6;
  localparam logic [3:0] StHttp     = 4'd7;
  localparam logic [3:0] StHttps    = 4'd8;

  // Result queue
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  field_id;
    logic [7:0]  data_byte;
    logic [15:0] command;
    logic [15:0] flag_bits;
    logic [3:0]  status;
    logic        run_last;
  } out_t;

  // Up to two results per frame byte, data first
  typedef struct packed {
    logic [1:0] valid;
    out_t       res0;
    out_t       res1;
  } push_t;

endpackage

// ----- rtl/version_response_frame_parser.sv -----
// Version-response frame parser. Takes one frame byte per item (frame_end on
// the last byte), skips the 10-byte header while latching command and flags,
// and for the version-report command walks the flag-selected length-prefixed
// fields, emitting each body byte as a data result tagged by field id; the two
// version fields are split at their first comma, which is not emitted. The
// frame's last byte also yields a status result (command, flags, error code).
// Data results are provisional until a status of 0 follows. Throughput is one
// item per cycle: an input register feeds the parse step, which updates its
// small state and pushes up to two results into a 4-entry result queue. Input
// stalls only while the queue has fewer than two free slots, i.e. when the
// consumer stalls or a frame-end byte produces both a data and a status result.
// An accepted item waits in the input register until the queue has room; its
// results are then written into the result queue, from which the output reads.
module version_response_frame_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  vrfp_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output vrfp_pkg::out_t  out_data_o
);
  import vrfp_pkg::*;

  // input register
  logic  in_valid_q;
  in_t   in_q;
  logic  room;
  logic  fire;
  push_t push;

  // parse the held item once the queue can take its results
  assign fire       = in_valid_q && room;
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  vrfp_step u_step (
    .clk_i,
    .rst_ni,
    .fire_i (fire),
    .in_i   (in_q),
    .push_o (push)
  );

  vrfp_outq u_outq (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .room_o      (room),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

endmodule

// ----- rtl/vrfp_step.sv -----
module vrfp_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  vrfp_pkg::in_t in_i,
  output vrfp_pkg::push_t push_o
);
  import vrfp_pkg::*;

  typedef enum logic [2:0] {
    PhHeader,
    PhLenHi,
    PhLenLo,
    PhBody,
    PhDone,
    PhSkip
  } phase_e;

  typedef struct packed {
    logic       found;
    logic [2:0] idx;
  } next_t;

  function automatic logic slot_present(input logic [2:0] i, input logic [15:0] f);
    logic p;
    p = 1'b0;
    unique case (i)
      SlotSubdev: p = f[FlagSubdev];
      SlotModule: p = f[FlagModule];
      SlotMcu:    p = f[FlagMcu];
      SlotMd5:    p = f[FlagMd5];
      SlotUrl:    p = f[FlagHttp] | f[FlagHttps];
      default:    p = 1'b0;
    endcase
    return p;
  endfunction

  // First present slot at or after start
  function automatic next_t first_slot(input logic [2:0] start, input logic [15:0] f);
    next_t n;
    n = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (3'(i) >= start && slot_present(3'(i), f)) begin
        n.found = 1'b1;
        n.idx   = 3'(i);
      end
    end
    return n;
  endfunction

  function automatic logic [3:0] slot_error(input logic [2:0] i, input logic [15:0] f);
    logic [3:0] e;
    if (i < SlotUrl) begin
      e = StSubdev + {1'b0, i};
    end else begin
      e = f[FlagHttp] ? StHttp : StHttps;
    end
    return e;
  endfunction

  phase_e      phase_q, phase_d;
  logic [3:0]  hcnt_q, hcnt_d;
  logic [15:0] cmd_q, cmd_d;
  logic [15:0] flags_q, flags_d;
  logic [2:0]  idx_q, idx_d;
  logic [15:0] left_q, left_d;
  logic        comma_q, comma_d;
  logic [3:0]  err_q, err_d;

  logic        adv;
  logic [2:0]  adv_start;
  next_t       nxt;
  logic        ver;
  logic        emit;
  logic [2:0]  fid;
  logic [3:0]  st;
  logic [15:0] st_cmd, st_flags;
  out_t        data_r, stat_r;

  always_comb begin
    phase_d  = phase_q;
    hcnt_d   = hcnt_q;
    cmd_d    = cmd_q;
    flags_d  = flags_q;
    idx_d    = idx_q;
    left_d   = left_q;
    comma_d  = comma_q;
    err_d    = err_q;
    adv      = 1'b0;
    adv_start = '0;
    emit     = 1'b0;
    fid      = FidSubdev;
    ver      = (idx_q == SlotModule) || (idx_q == SlotMcu);
    st       = StOk;
    st_cmd   = '0;
    st_flags = '0;

    unique case (phase_q)
      PhHeader: begin
        if (hcnt_q == 4'(CmdHiAt) || hcnt_q == 4'(CmdHiAt + 1)) begin
          cmd_d = {cmd_q[7:0], in_i.frame_byte};
        end else if (hcnt_q == 4'(FlgHiAt) || hcnt_q == 4'(FlgHiAt + 1)) begin
          flags_d = {flags_q[7:0], in_i.frame_byte};
        end
        if (hcnt_q >= 4'(HdrLen - 1)) begin
          hcnt_d = '0;
          if (cmd_q == RespCmd) begin
            adv = 1'b1;
          end else begin
            err_d   = StUnknown;
            phase_d = PhSkip;
          end
        end else begin
          hcnt_d = hcnt_q + 4'd1;
        end
      end
      PhLenHi: begin
        left_d  = {in_i.frame_byte, 8'h00};
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        left_d  = {left_q[15:8], in_i.frame_byte};
        comma_d = 1'b0;
        if (left_d == '0) begin
          adv       = 1'b1;
          adv_start = idx_q + 3'd1;
        end else begin
          phase_d = PhBody;
        end
      end
      PhBody: begin
        if (ver && !comma_q && in_i.frame_byte == CommaChar) begin
          comma_d = 1'b1;
        end else begin
          emit = 1'b1;
        end
        unique case (idx_q)
          SlotSubdev: fid = FidSubdev;
          SlotModule: fid = comma_q ? FidModuleSw : FidModuleHw;
          SlotMcu:    fid = comma_q ? FidMcuSw : FidMcuHw;
          SlotMd5:    fid = FidMd5;
          default:    fid = FidUrl;
        endcase
        left_d = left_q - 16'd1;
        if (left_d == '0) begin
          if (ver && !comma_d) begin
            err_d   = slot_error(idx_q, flags_q);
            phase_d = PhDone;
          end else begin
            adv       = 1'b1;
            adv_start = idx_q + 3'd1;
          end
        end
      end
      default: begin
        // done or skipping: bytes are dropped until frame end
      end
    endcase

    nxt = first_slot(adv_start, flags_d);
    if (adv) begin
      if (nxt.found) begin
        idx_d   = nxt.idx;
        left_d  = '0;
        comma_d = 1'b0;
        phase_d = PhLenHi;
      end else begin
        phase_d = PhDone;
      end
    end

    // Status reflects the state after this byte
    if (phase_d == PhHeader) begin
      st = StShort;
    end else begin
      st_cmd   = cmd_d;
      st_flags = flags_d;
      if (phase_d == PhLenHi || phase_d == PhLenLo || phase_d == PhBody) begin
        st = slot_error(idx_d, flags_d);
      end else begin
        st = err_d;
      end
    end

    if (in_i.frame_end) begin
      phase_d = PhHeader;
      hcnt_d  = '0;
      cmd_d   = '0;
      flags_d = '0;
      idx_d   = '0;
      left_d  = '0;
      comma_d = 1'b0;
      err_d   = StOk;
    end
  end

  always_comb begin
    data_r           = '0;
    data_r.kind      = KindData;
    data_r.field_id  = fid;
    data_r.data_byte = in_i.frame_byte;
    data_r.run_last  = !in_i.frame_end;

    stat_r           = '0;
    stat_r.kind      = KindStatus;
    stat_r.command   = st_cmd;
    stat_r.flag_bits = st_flags;
    stat_r.status    = st;
    stat_r.run_last  = 1'b1;

    push_o = '0;
    if (fire_i) begin
      if (emit) begin
        push_o.valid[0] = 1'b1;
        push_o.res0     = data_r;
        push_o.valid[1] = in_i.frame_end;
        push_o.res1     = stat_r;
      end else begin
        push_o.valid[0] = in_i.frame_end;
        push_o.res0     = stat_r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      hcnt_q  <= '0;
      cmd_q   <= '0;
      flags_q <= '0;
      idx_q   <= '0;
      left_q  <= '0;
      comma_q <= 1'b0;
      err_q   <= StOk;
    end else if (fire_i) begin
      phase_q <= phase_d;
      hcnt_q  <= hcnt_d;
      cmd_q   <= cmd_d;
      flags_q <= flags_d;
      idx_q   <= idx_d;
      left_q  <= left_d;
      comma_q <= comma_d;
      err_q   <= err_d;
    end
  end

endmodule

// ----- rtl/vrfp_outq.sv -----
module vrfp_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vrfp_pkg::push_t   push_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vrfp_pkg::out_t    out_data_o
);
  import vrfp_pkg::*;

  out_t              mem_q [QDepth];
  logic [QPtrW-1:0]  wr_q, rd_q;
  logic [QCntW-1:0]  cnt_q;
  logic              pop;
  logic [QCntW-1:0]  n_push;
  logic [QPtrW-1:0]  wr_p1;

  assign pop         = out_valid_o && out_ready_i;
  assign n_push      = QCntW'(push_i.valid[0]) + QCntW'(push_i.valid[1]);
  assign wr_p1       = wr_q + QPtrW'(1);
  // room for the worst case of two results from one byte
  assign room_o      = cnt_q <= QCntW'(QDepth - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.valid[0]) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.valid[1]) begin
      mem_q[wr_p1] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPtrW'(n_push);
      if (pop) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + n_push - QCntW'(pop);
    end
  end

endmodule

// ----- rtl/vrfp_checker.sv -----
module vrfp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input vrfp_pkg::out_t out_data_o
);
  import vrfp_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // status always closes the run of results for its byte
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KindStatus |-> out_data_o.run_last)
    else $error("status result without run_last");

  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KindData |->
      out_data_o.command == '0 && out_data_o.flag_bits == '0 &&
      out_data_o.status == StOk && out_data_o.field_id <= FidUrl)
    else $error("data result carries status fields");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KindStatus |->
      out_data_o.field_id == '0 && out_data_o.data_byte == '0 &&
      out_data_o.status <= StHttps)
    else $error("malformed status result");

  // short frame reports zero command and flags
  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KindStatus && out_data_o.status == StShort |->
      out_data_o.command == '0 && out_data_o.flag_bits == '0)
    else $error("short frame status carries header words");

endmodule

bind version_response_frame_parser vrfp_checker u_vrfp_checker (
  .clk_i,
  .rst_ni,
  .out_valid_o,
  .out_ready_i,
  .out_data_o
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import vrfp_pkg::*;

  // Pacing of the two handshakes
  typedef enum logic [1:0] {
    PaceFree,
    PaceSendGaps,
    PaceRecvStalls,
    PaceBoth
  } pace_e;

  // Frame walk states of the byte parser
  typedef enum logic [2:0] {
    PhHeader,
    PhLenHi,
    PhLenLo,
    PhBody,
    PhDone,
    PhSkip
  } parse_ph_e;

  // One frame byte waiting to go out, with its pacing
  typedef struct packed {
    in_t   item;
    pace_e pace;
    logic  drain;   // hold off until every expected result has arrived
  } stim_t;

  localparam int unsigned PhaseItems = 175;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  in_t   in_data_i   = '0;
  logic  out_ready_i = 1'b0;
  logic  in_ready_o;
  logic  out_valid_o;
  out_t  out_data_o;

  logic  in_taken    = 1'b0;
  pace_e cur_pace    = PaceFree;

  stim_t      pending[$];
  out_t       expected_results[$];
  logic [7:0] frame_buf[$];

  // Parser state mirrored by the testbench
  parse_ph_e   parse_ph;
  int unsigned hdr_cnt;
  logic [15:0] cmd_q;
  logic [15:0] flags_q;
  logic [2:0]  slot_q;
  logic [15:0] left_q;
  logic        comma_q;
  logic [3:0]  err_q;

  int unsigned mismatches  = 0;
  int unsigned bytes_taken = 0;
  int unsigned data_seen   = 0;
  int unsigned frames_seen = 0;

  version_response_frame_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Frame parser prediction
  // ---------------------------------------------------------------------------

  function automatic logic slot_selected(input logic [15:0] flags, input logic [2:0] s);
    case (s)
      SlotSubdev: return flags[FlagSubdev];
      SlotModule: return flags[FlagModule];
      SlotMcu:    return flags[FlagMcu];
      SlotMd5:    return flags[FlagMd5];
      SlotUrl:    return flags[FlagHttp] | flags[FlagHttps];
      default:    return 1'b0;
    endcase
  endfunction

  // Status reported when the frame breaks off inside a field
  function automatic logic [3:0] slot_error(input logic [2:0] s);
    case (s)
      SlotSubdev: return StSubdev;
      SlotModule: return StModule;
      SlotMcu:    return StMcu;
      SlotMd5:    return StMd5;
      default:    return flags_q[FlagHttp] ? StHttp : StHttps;
    endcase
  endfunction

  task automatic clear_parser();
    parse_ph = PhHeader;
    hdr_cnt  = 0;
    cmd_q    = '0;
    flags_q  = '0;
    slot_q   = '0;
    left_q   = '0;
    comma_q  = 1'b0;
    err_q    = '0;
  endtask

  // Move to the next flag-selected field at or after start, else finish
  task automatic seek_slot(input int start);
    bit found;
    found = 1'b0;
    for (int i = start; i < NumSlots; i++) begin
      if (!found && slot_selected(flags_q, 3'(i))) begin
        found    = 1'b1;
        slot_q   = 3'(i);
        left_q   = '0;
        comma_q  = 1'b0;
        parse_ph = PhLenHi;
      end
    end
    if (!found) parse_ph = PhDone;
  endtask

  task automatic predict_item(input in_t it);
    out_t       data_res;
    out_t       stat_res;
    bit         has_data;
    bit         has_stat;
    bit         ver;
    logic [7:0] b;
    data_res = '0;
    stat_res = '0;
    has_data = 1'b0;
    has_stat = 1'b0;
    b = it.frame_byte;
    case (parse_ph)
      PhHeader: begin
        if (hdr_cnt == CmdHiAt || hdr_cnt == CmdHiAt + 1) begin
          cmd_q = {cmd_q[7:0], b};
        end else if (hdr_cnt == FlgHiAt || hdr_cnt == FlgHiAt + 1) begin
          flags_q = {flags_q[7:0], b};
        end
        if (hdr_cnt + 1 >= HdrLen) begin
          hdr_cnt = 0;
          if (cmd_q == RespCmd) begin
            seek_slot(0);
          end else begin
            err_q    = StUnknown;
            parse_ph = PhSkip;
          end
        end else begin
          hdr_cnt++;
        end
      end
      PhLenHi: begin
        left_q   = {b, 8'h00};
        parse_ph = PhLenLo;
      end
      PhLenLo: begin
        left_q[7:0] = b;
        comma_q     = 1'b0;
        if (left_q == 16'd0) seek_slot(int'(slot_q) + 1);
        else parse_ph = PhBody;
      end
      PhBody: begin
        ver = (slot_q == SlotModule || slot_q == SlotMcu);
        if (ver && !comma_q && b == CommaChar) begin
          // first comma splits hw from sw and is swallowed
          comma_q = 1'b1;
        end else begin
          has_data           = 1'b1;
          data_res.kind      = KindData;
          data_res.data_byte = b;
          case (slot_q)
            SlotSubdev: data_res.field_id = FidSubdev;
            SlotModule: data_res.field_id = comma_q ? FidModuleSw : FidModuleHw;
            SlotMcu:    data_res.field_id = comma_q ? FidMcuSw : FidMcuHw;
            SlotMd5:    data_res.field_id = FidMd5;
            default:    data_res.field_id = FidUrl;
          endcase
        end
        left_q = left_q - 16'd1;
        if (left_q == 16'd0) begin
          if (ver && !comma_q) begin
            // version field without a comma: latch the error, ignore the rest
            err_q    = slot_error(slot_q);
            parse_ph = PhDone;
          end else begin
            seek_slot(int'(slot_q) + 1);
          end
        end
      end
      default: ;
    endcase

    if (it.frame_end) begin
      has_stat      = 1'b1;
      stat_res.kind = KindStatus;
      if (parse_ph == PhHeader) begin
        stat_res.status = StShort;   // command and flags stay zero
      end else begin
        stat_res.command   = cmd_q;
        stat_res.flag_bits = flags_q;
        if (parse_ph == PhLenHi || parse_ph == PhLenLo || parse_ph == PhBody)
          stat_res.status = slot_error(slot_q);
        else
          stat_res.status = err_q;
      end
      clear_parser();
    end

    if (has_stat) stat_res.run_last = 1'b1;
    else if (has_data) data_res.run_last = 1'b1;
    if (has_data) expected_results.push_back(data_res);
    if (has_stat) expected_results.push_back(stat_res);
  endtask

  // ---------------------------------------------------------------------------
  // Frame construction
  // ---------------------------------------------------------------------------

  function automatic bit sender_gap(input pace_e p);
    case (p)
      PaceSendGaps: return $urandom_range(0, 99) < 58;
      PaceBoth:     return $urandom_range(0, 99) < 25;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall(input pace_e p);
    case (p)
      PaceRecvStalls: return $urandom_range(0, 99) < 58;
      PaceBoth:       return $urandom_range(0, 99) < 25;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic put_header(input logic [15:0] cmd, input logic [15:0] flags);
    repeat (4) frame_buf.push_back(rand_byte());
    frame_buf.push_back(cmd[15:8]);
    frame_buf.push_back(cmd[7:0]);
    frame_buf.push_back(flags[15:8]);
    frame_buf.push_back(flags[7:0]);
    repeat (2) frame_buf.push_back(rand_byte());
  endtask

  task automatic put_len(input logic [15:0] len);
    frame_buf.push_back(len[15:8]);
    frame_buf.push_back(len[7:0]);
  endtask

  // Random frame: mostly well-formed version responses, the rest other
  // commands, short frames and plain noise
  task automatic make_frame();
    int unsigned pick;
    int unsigned len;
    int unsigned comma_at;
    int unsigned cut;
    logic [15:0] flags;
    logic [15:0] cmd;
    logic [7:0]  b;
    bit          ver;
    bit          stop;
    frame_buf = {};
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      flags = '0;
      flags[FlagSubdev] = 1'($urandom_range(0, 1));
      flags[FlagModule] = 1'($urandom_range(0, 1));
      flags[FlagMcu]    = 1'($urandom_range(0, 1));
      flags[FlagMd5]    = 1'($urandom_range(0, 1));
      flags[FlagHttp]   = 1'($urandom_range(0, 1));
      flags[FlagHttps]  = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) flags = flags | 16'($urandom_range(0, 65535));
      put_header(RespCmd, flags);
      stop = 1'b0;
      for (int s = 0; s < NumSlots; s++) begin
        if (!stop && slot_selected(flags, 3'(s))) begin
          ver = (3'(s) == SlotModule || 3'(s) == SlotMcu);
          if ($urandom_range(0, 19) == 0) begin
            // huge length prefix, frame breaks off inside the body
            put_len(16'($urandom_range(256, 65535)));
            repeat ($urandom_range(0, 4)) frame_buf.push_back(rand_byte());
            stop = 1'b1;
          end else begin
            len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 19) == 0) len = $urandom_range(7, 20);
            put_len(16'(len));
            comma_at = len;
            if (ver && len > 0 && $urandom_range(0, 7) != 0)
              comma_at = $urandom_range(0, len - 1);
            for (int i = 0; i < len; i++) begin
              b = rand_byte();
              if (ver && i < comma_at && b == CommaChar) b = b + 8'd1;
              if (ver && i == comma_at) b = CommaChar;
              frame_buf.push_back(b);
            end
          end
        end
      end
      repeat ($urandom_range(0, 2)) frame_buf.push_back(rand_byte());
      if ($urandom_range(0, 4) == 0) begin
        cut = $urandom_range(1, frame_buf.size());
        while (frame_buf.size() > cut) void'(frame_buf.pop_back());
      end
    end else if (pick < 78) begin
      cmd = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 1) == 0) cmd = RespCmd ^ (16'd1 << $urandom_range(0, 15));
      if (cmd == RespCmd) cmd = cmd ^ 16'd1;
      put_header(cmd, 16'($urandom_range(0, 65535)));
      repeat ($urandom_range(0, 6)) frame_buf.push_back(rand_byte());
    end else if (pick < 88) begin
      repeat ($urandom_range(1, HdrLen - 1)) frame_buf.push_back(rand_byte());
    end else begin
      repeat ($urandom_range(1, 24)) frame_buf.push_back(rand_byte());
    end
  endtask

  task automatic queue_frame(input pace_e pace, input bit drain_first);
    stim_t s;
    for (int i = 0; i < frame_buf.size(); i++) begin
      s.item.frame_byte = frame_buf[i];
      s.item.frame_end  = (i == frame_buf.size() - 1);
      s.pace            = pace;
      s.drain           = drain_first && (i == 0);
      pending.push_back(s);
    end
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: new items and ready change on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : driver_p
    stim_t next_item;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      out_ready_i <= 1'b0;
    end else begin
      // a presented item is held until the rising edge takes it
      if (!in_valid_i || in_taken) begin
        if (pending.size() != 0 && !(pending[0].drain && expected_results.size() != 0)
            && !sender_gap(pending[0].pace)) begin
          next_item = pending.pop_front();
          in_data_i  <= next_item.item;
          cur_pace   <= next_item.pace;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= !receiver_stall(cur_pace);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results, then predict from the item taken on this edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor_p
    out_t want;
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got %0h", $time, out_data_o);
      end else begin
        want = expected_results.pop_front();
        check_field("kind", 16'(want.kind), 16'(out_data_o.kind));
        check_field("field_id", 16'(want.field_id), 16'(out_data_o.field_id));
        check_field("data_byte", 16'(want.data_byte), 16'(out_data_o.data_byte));
        check_field("command", want.command, out_data_o.command);
        check_field("flag_bits", want.flag_bits, out_data_o.flag_bits);
        check_field("status", 16'(want.status), 16'(out_data_o.status));
        check_field("run_last", 16'(want.run_last), 16'(out_data_o.run_last));
        if (want.kind == KindStatus) frames_seen++;
        else data_seen++;
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      bytes_taken++;
      predict_item(in_data_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : main_p
    pace_e       pace;
    int unsigned phase_items;
    bit          first_frame;
    clear_parser();

    // short frame: ends on its first byte
    frame_buf = {8'h00};
    queue_frame(PaceFree, 1'b0);
    // unknown command, all-ones header, ends on the last header byte
    frame_buf = {8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
    queue_frame(PaceFree, 1'b0);
    // response: empty subdev id, module split at a leading comma, mcu field
    // without a comma stops the walk, then a trailing byte is ignored
    frame_buf = {8'h00, 8'h00, 8'h00, 8'h00, RespCmd[15:8], RespCmd[7:0],
                 8'h00, 8'((1 << FlagSubdev) | (1 << FlagModule) | (1 << FlagMcu)),
                 8'h00, 8'h00,
                 8'h00, 8'h00,
                 8'h00, 8'h02, CommaChar, 8'hff,
                 8'h00, 8'h01, 8'h78,
                 8'h55};
    queue_frame(PaceFree, 1'b0);

    // random frames under each pacing, the first of each phase on an empty pipe
    for (int p = 0; p < 4; p++) begin
      pace        = pace_e'(p);
      phase_items = 0;
      first_frame = 1'b1;
      while (phase_items < PhaseItems) begin
        make_frame();
        phase_items += frame_buf.size();
        queue_frame(pace, first_frame);
        first_frame = 1'b0;
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    // keep clocking so any stray result shows up
    repeat (10) @(posedge clk_i);

    $display("Sent %0d frame bytes; checked %0d field bytes and %0d frame statuses.",
             bytes_taken, data_seen, frames_seen);
    $display("Pacing ran free, with sender gaps, receiver stalls and both; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("** version_response_frame_parser: PASSED **");
    end else begin
      $display("** version_response_frame_parser: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("Timed out with %0d results outstanding.", expected_results.size());
    $display("** version_response_frame_parser: FAILED **");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/vrfp_pkg.sv
rtl/vrfp_step.sv
rtl/vrfp_outq.sv
rtl/version_response_frame_parser.sv
rtl/vrfp_checker.sv
sim/tb.sv
